// ===== hdl/bfsa_pkg.sv =====
// shared types and constants of the best-fit segment allocator
package bfsa_pkg;

   localparam int AW         = 21;
   localparam int BYTES_W    = 24;
   localparam int ST_W       = 2;
   localparam int UNIT_SHIFT = 4;
   localparam int UNIT_BYTES = 1 << UNIT_SHIFT;

   localparam logic [AW:0]   HEAP_UNITS     = 22'd1048576;
   localparam logic [AW-1:0] LEN_MAX        = 21'h1FFFFF;
   localparam logic [AW-1:0] HEAP_LIMIT_RST = 21'd1048576;
   localparam logic [AW-1:0] GROW_RST       = 21'd1024;

   localparam logic [ST_W-1:0] ST_OK         = 2'd0;
   localparam logic [ST_W-1:0] ST_NO_HEAP    = 2'd1;
   localparam logic [ST_W-1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [ST_W-1:0] ST_NULL_FREE  = 2'd3;

   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_HEAP_LIMIT = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_GROW       = 2'd1;

   typedef struct packed {
      logic [AW-1:0] base;
      logic [AW-1:0] len;
   } seg_type;

   localparam int SEG_W = $bits(seg_type);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SRCH_INIT, S_SRCH, S_GROW, S_INS_SCAN, S_INS_APPLY,
      S_MOVE, S_INS_WRITE, S_INS_END, S_TAKE, S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_LOAD, CMD_SRCH_INIT, CMD_SRCH_STEP, CMD_FREE_SETUP,
      CMD_GROW_SETUP, CMD_INS_STEP, CMD_APPLY, CMD_MOVE_STEP, CMD_INS_WRITE,
      CMD_HEAP_BUMP, CMD_TAKE, CMD_FAIL, CMD_PUBLISH
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [ST_W-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic null_addr;
      logic zero_units;
      logic empty;
      logic scan_done;
      logic best_valid;
      logic exact;
      logic over_limit;
      logic merge_prev;
      logic merge_next;
      logic table_full;
      logic move_done;
      logic rsp_free;
   } stat_type;

endpackage

// ===== hdl/bfsa_ram.sv =====
// generic simple dual-port ram with registered read
module bfsa_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/bfsa_ctrl.sv =====
// sequencing state machine of the allocator
module bfsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  bfsa_pkg::stat_type stat,
   output bfsa_pkg::cmd_type  cmd
);
   import bfsa_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      grow_ff, grow_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         grow_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         grow_ff  <= grow_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      grow_in  = grow_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
               grow_in  = 1'b0;
            end
         end
         S_DECODE: begin
            if (stat.is_free) begin
               if (stat.null_addr || stat.zero_units) state_in = S_FINISH;
               else state_in = S_INS_SCAN;
            end else begin
               state_in = S_SRCH_INIT;
            end
         end
         S_SRCH_INIT: state_in = stat.empty ? S_GROW : S_SRCH;
         S_SRCH: begin
            if (stat.scan_done) state_in = stat.best_valid ? S_TAKE : S_GROW;
         end
         S_GROW: begin
            if (stat.over_limit) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_INS_SCAN;
               grow_in  = 1'b1;
            end
         end
         S_INS_SCAN: begin
            if (stat.scan_done) state_in = S_INS_APPLY;
         end
         S_INS_APPLY: begin
            priority if (stat.merge_prev && stat.merge_next) begin
               state_in = S_MOVE;
               ret_in   = S_INS_END;
            end else if (stat.merge_prev || stat.merge_next) begin
               state_in = S_INS_END;
            end else if (stat.table_full) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_MOVE;
               ret_in   = S_INS_WRITE;
            end
         end
         S_MOVE: begin
            if (stat.move_done) state_in = ret_ff;
         end
         S_INS_WRITE: state_in = S_INS_END;
         S_INS_END: begin
            if (grow_ff) begin
               state_in = S_SRCH_INIT;
               grow_in  = 1'b0;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_TAKE: begin
            if (stat.exact) begin
               state_in = S_MOVE;
               ret_in   = S_FINISH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op     = CMD_NONE;
      cmd.code   = ST_OK;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = CMD_LOAD;
         end
         S_DECODE: begin
            if (stat.is_free) begin
               priority if (stat.null_addr) begin
                  cmd.op   = CMD_FAIL;
                  cmd.code = ST_NULL_FREE;
               end else if (!stat.zero_units) begin
                  cmd.op = CMD_FREE_SETUP;
               end else begin
                  cmd.op = CMD_NONE;
               end
            end
         end
         S_SRCH_INIT: begin
            if (!stat.empty) cmd.op = CMD_SRCH_INIT;
         end
         S_SRCH: cmd.op = CMD_SRCH_STEP;
         S_GROW: begin
            if (stat.over_limit) begin
               cmd.op   = CMD_FAIL;
               cmd.code = ST_NO_HEAP;
            end else begin
               cmd.op = CMD_GROW_SETUP;
            end
         end
         S_INS_SCAN: cmd.op = CMD_INS_STEP;
         S_INS_APPLY: begin
            if (!stat.merge_prev && !stat.merge_next && stat.table_full) begin
               cmd.op   = CMD_FAIL;
               cmd.code = ST_TABLE_FULL;
            end else begin
               cmd.op = CMD_APPLY;
            end
         end
         S_MOVE: cmd.op = CMD_MOVE_STEP;
         S_INS_WRITE: cmd.op = CMD_INS_WRITE;
         S_INS_END: begin
            if (grow_ff) cmd.op = CMD_HEAP_BUMP;
         end
         S_TAKE: cmd.op = CMD_TAKE;
         S_FINISH: begin
            if (stat.rsp_free) cmd.op = CMD_PUBLISH;
         end
         default: cmd.op = CMD_NONE;
      endcase
   end

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CMD_PUBLISH) |-> stat.rsp_free)
      else $error("result published over a pending result");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DECODE))
      else $error("accepted request not decoded");

endmodule

// ===== hdl/bfsa_dp.sv =====
// allocator datapath: segment table, scan and shift engine, result register
module bfsa_dp #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bfsa_pkg::cmd_type                   cmd,
   output bfsa_pkg::stat_type                  stat,
   input  logic                                req_command,
   input  logic [bfsa_pkg::BYTES_W-1:0]        req_bytes,
   input  logic [bfsa_pkg::AW-1:0]             req_address,
   input  logic [bfsa_pkg::AW-1:0]             req_units,
   input  logic                                csr_write,
   input  logic [bfsa_pkg::CSR_IW-1:0]         csr_index,
   input  logic [bfsa_pkg::AW-1:0]             csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [2*bfsa_pkg::AW+bfsa_pkg::ST_W-1:0] rsp_payload
);
   import bfsa_pkg::*;

   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int PW = 2 * AW + ST_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

   logic [AW-1:0]   limit_ff, limit_in, grow_cfg_ff, grow_cfg_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [IW-1:0]   rover_ff, rover_in;
   logic [AW-1:0]   heap_top_ff, heap_top_in;
   logic            pend_ff, pend_in, stop_ff, stop_in, best_v_ff, best_v_in;
   logic            next_v_ff, next_v_in, rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]   left_ff, left_in;

   logic            is_free_ff, is_free_in;
   logic [AW-1:0]   need_ff, need_in, addr_ff, addr_in, units_ff, units_in;
   logic [AW-1:0]   ins_base_ff, ins_base_in, ins_len_ff, ins_len_in;
   logic [IW-1:0]   rd_ff, rd_in, pidx_ff, pidx_in, best_idx_ff, best_idx_in;
   logic            dir_up_ff, dir_up_in;
   seg_type         best_ff, best_in, prev_ff, prev_in, next_ff, next_in;
   logic [CW-1:0]   pos_ff, pos_in;
   logic [ST_W-1:0] res_st_ff, res_st_in;
   logic [AW-1:0]   res_addr_ff, res_addr_in, res_grant_ff, res_grant_in;
   logic [PW-1:0]   rsp_data_ff, rsp_data_in;

   logic            ram_we;
   logic [IW-1:0]   ram_waddr;
   logic [SEG_W-1:0] ram_wdata, ram_rdata;
   seg_type         rseg;

   logic [CW-1:0]   cnt_m1, cnt_m2, pos_m1_w, left_m1;
   logic [IW-1:0]   pos_idx, pos_m1, srch_first, srch_nxt, start, idx_m1;
   logic            fit, hit_exact, ins_gt, merge_prev, merge_next;
   logic [AW+1:0]   sum3;
   logic [AW:0]     sum2, limit_w, grow_end;
   logic [AW-1:0]   grow_amt, sat3, sat2, cut_len;
   logic [BYTES_W:0] bytes_sum;
   logic [BYTES_W-UNIT_SHIFT:0] need_q;

   bfsa_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_ff),
      .rdata (ram_rdata)
   );

   assign rseg      = seg_type'(ram_rdata);
   assign cnt_m1    = count_ff - 1'b1;
   assign cnt_m2    = count_ff - CW'(2);
   assign left_m1   = left_ff - 1'b1;
   assign pos_m1_w  = pos_ff - 1'b1;
   assign pos_idx   = pos_ff[IW-1:0];
   assign pos_m1    = pos_m1_w[IW-1:0];
   assign idx_m1    = best_idx_ff - 1'b1;
   assign start     = ({1'b0, rover_ff} < count_ff) ? rover_ff : cnt_m1[IW-1:0];
   assign srch_first = (({1'b0, start} + 1'b1) == count_ff) ? '0 : start + 1'b1;
   assign srch_nxt  = (({1'b0, rd_ff} + 1'b1) == count_ff) ? '0 : rd_ff + 1'b1;

   assign fit       = (rseg.len >= need_ff) && (!best_v_ff || rseg.len < best_ff.len);
   assign hit_exact = rseg.len == need_ff;
   assign ins_gt    = rseg.base > ins_base_ff;

   assign merge_prev = (pos_ff != '0) &&
                       (({1'b0, prev_ff.base} + {1'b0, prev_ff.len}) == {1'b0, ins_base_ff});
   assign merge_next = next_v_ff &&
                       (({1'b0, ins_base_ff} + {1'b0, ins_len_ff}) == {1'b0, next_ff.base});
   assign sum3 = {2'b0, prev_ff.len} + {2'b0, ins_len_ff} +
                 (merge_next ? {2'b0, next_ff.len} : '0);
   assign sat3 = (sum3 > {2'b0, LEN_MAX}) ? LEN_MAX : sum3[AW-1:0];
   assign sum2 = {1'b0, next_ff.len} + {1'b0, ins_len_ff};
   assign sat2 = (sum2 > {1'b0, LEN_MAX}) ? LEN_MAX : sum2[AW-1:0];

   assign grow_amt = (need_ff > grow_cfg_ff) ? need_ff : grow_cfg_ff;
   assign limit_w  = ({1'b0, limit_ff} < HEAP_UNITS) ? {1'b0, limit_ff} : HEAP_UNITS;
   assign grow_end = {1'b0, heap_top_ff} + {1'b0, grow_amt};
   assign cut_len  = best_ff.len - need_ff;

   assign bytes_sum = {1'b0, req_bytes} + (BYTES_W + 1)'(UNIT_BYTES - 1);
   assign need_q    = bytes_sum[BYTES_W:UNIT_SHIFT];

   always_comb begin
      stat.is_free    = is_free_ff;
      stat.null_addr  = addr_ff == '0;
      stat.zero_units = units_ff == '0;
      stat.empty      = count_ff == '0;
      stat.scan_done  = !pend_ff && (left_ff == '0 || stop_ff);
      stat.best_valid = best_v_ff;
      stat.exact      = best_ff.len == need_ff;
      stat.over_limit = grow_end > limit_w;
      stat.merge_prev = merge_prev;
      stat.merge_next = merge_next;
      stat.table_full = count_ff >= MAX_CNT;
      stat.move_done  = !pend_ff && left_ff == '0;
      stat.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      limit_in     = limit_ff;
      grow_cfg_in  = grow_cfg_ff;
      count_in     = count_ff;
      rover_in     = rover_ff;
      heap_top_in  = heap_top_ff;
      pend_in      = pend_ff;
      stop_in      = stop_ff;
      best_v_in    = best_v_ff;
      next_v_in    = next_v_ff;
      left_in      = left_ff;
      is_free_in   = is_free_ff;
      need_in      = need_ff;
      addr_in      = addr_ff;
      units_in     = units_ff;
      ins_base_in  = ins_base_ff;
      ins_len_in   = ins_len_ff;
      rd_in        = rd_ff;
      pidx_in      = pidx_ff;
      best_idx_in  = best_idx_ff;
      dir_up_in    = dir_up_ff;
      best_in      = best_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      pos_in       = pos_ff;
      res_st_in    = res_st_ff;
      res_addr_in  = res_addr_ff;
      res_grant_in = res_grant_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_idx;
      ram_wdata    = {ins_base_ff, ins_len_ff};

      if (csr_write) begin
         if (csr_index == CSR_HEAP_LIMIT) limit_in = csr_data;
         if (csr_index == CSR_GROW) grow_cfg_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (cmd.op)
         CMD_NONE: begin
         end
         CMD_LOAD: begin
            is_free_in   = req_command;
            need_in      = AW'(need_q) + 1'b1;
            addr_in      = req_address;
            units_in     = req_units;
            res_st_in    = ST_OK;
            res_addr_in  = '0;
            res_grant_in = '0;
         end
         CMD_SRCH_INIT: begin
            rd_in     = srch_first;
            left_in   = count_ff;
            pend_in   = 1'b0;
            stop_in   = 1'b0;
            best_v_in = 1'b0;
         end
         CMD_SRCH_STEP: begin
            if (pend_ff && fit) begin
               best_v_in   = 1'b1;
               best_idx_in = pidx_ff;
               best_in     = rseg;
               if (hit_exact) stop_in = 1'b1;
            end
            pend_in = (left_ff != '0) && !stop_ff && !(pend_ff && fit && hit_exact);
            if (pend_in) begin
               pidx_in = rd_ff;
               rd_in   = srch_nxt;
               left_in = left_m1;
            end
         end
         CMD_FREE_SETUP, CMD_GROW_SETUP: begin
            if (cmd.op == CMD_FREE_SETUP) begin
               ins_base_in = addr_ff - 1'b1;
               ins_len_in  = units_ff;
            end else begin
               ins_base_in = heap_top_ff;
               ins_len_in  = grow_amt;
            end
            rd_in     = '0;
            left_in   = count_ff;
            pend_in   = 1'b0;
            stop_in   = 1'b0;
            pos_in    = '0;
            next_v_in = 1'b0;
         end
         CMD_INS_STEP: begin
            if (pend_ff) begin
               if (ins_gt) begin
                  next_in   = rseg;
                  next_v_in = 1'b1;
                  pos_in    = {1'b0, pidx_ff};
                  stop_in   = 1'b1;
               end else begin
                  prev_in = rseg;
                  pos_in  = {1'b0, pidx_ff} + 1'b1;
               end
            end
            pend_in = (left_ff != '0) && !stop_ff && !(pend_ff && ins_gt);
            if (pend_in) begin
               pidx_in = rd_ff;
               rd_in   = rd_ff + 1'b1;
               left_in = left_m1;
            end
         end
         CMD_APPLY: begin
            pend_in = 1'b0;
            priority if (merge_prev) begin
               ram_we    = 1'b1;
               ram_waddr = pos_m1;
               ram_wdata = {prev_ff.base, sat3};
               rover_in  = pos_m1;
               if (merge_next) begin
                  dir_up_in = 1'b0;
                  rd_in     = pos_idx + 1'b1;
                  left_in   = cnt_m1 - pos_ff;
                  count_in  = cnt_m1;
               end else begin
                  left_in = '0;
               end
            end else if (merge_next) begin
               ram_we    = 1'b1;
               ram_waddr = pos_idx;
               ram_wdata = {ins_base_ff, sat2};
               rover_in  = (pos_ff != '0) ? pos_m1 : cnt_m1[IW-1:0];
               left_in   = '0;
            end else begin
               dir_up_in = 1'b1;
               rd_in     = cnt_m1[IW-1:0];
               left_in   = count_ff - pos_ff;
               count_in  = count_ff + 1'b1;
               rover_in  = (pos_ff != '0) ? pos_m1 : count_ff[IW-1:0];
            end
         end
         CMD_MOVE_STEP: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = dir_up_ff ? pidx_ff + 1'b1 : pidx_ff - 1'b1;
               ram_wdata = ram_rdata;
            end
            pend_in = left_ff != '0;
            if (pend_in) begin
               pidx_in = rd_ff;
               rd_in   = dir_up_ff ? rd_ff - 1'b1 : rd_ff + 1'b1;
               left_in = left_m1;
            end
         end
         CMD_INS_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = pos_idx;
            ram_wdata = {ins_base_ff, ins_len_ff};
         end
         CMD_HEAP_BUMP: begin
            heap_top_in = heap_top_ff + ins_len_ff;
         end
         CMD_TAKE: begin
            pend_in      = 1'b0;
            res_grant_in = need_ff;
            res_st_in    = ST_OK;
            if (best_ff.len == need_ff) begin
               res_addr_in = best_ff.base + 1'b1;
               dir_up_in   = 1'b0;
               rd_in       = best_idx_ff + 1'b1;
               left_in     = cnt_m1 - {1'b0, best_idx_ff};
               count_in    = cnt_m1;
               if (best_idx_ff != '0) rover_in = idx_m1;
               else rover_in = (count_ff > CW'(1)) ? cnt_m2[IW-1:0] : '0;
            end else begin
               ram_we      = 1'b1;
               ram_waddr   = best_idx_ff;
               ram_wdata   = {best_ff.base, cut_len};
               res_addr_in = best_ff.base + cut_len + 1'b1;
               left_in     = '0;
               rover_in    = (best_idx_ff != '0) ? idx_m1 : cnt_m1[IW-1:0];
            end
         end
         CMD_FAIL: begin
            res_st_in    = cmd.code;
            res_addr_in  = '0;
            res_grant_in = '0;
         end
         CMD_PUBLISH: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {res_st_ff, res_grant_ff, res_addr_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= HEAP_LIMIT_RST;
         grow_cfg_ff  <= GROW_RST;
         count_ff     <= '0;
         rover_ff     <= '0;
         heap_top_ff  <= '0;
         pend_ff      <= 1'b0;
         stop_ff      <= 1'b0;
         best_v_ff    <= 1'b0;
         next_v_ff    <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         grow_cfg_ff  <= grow_cfg_in;
         count_ff     <= count_in;
         rover_ff     <= rover_in;
         heap_top_ff  <= heap_top_in;
         pend_ff      <= pend_in;
         stop_ff      <= stop_in;
         best_v_ff    <= best_v_in;
         next_v_ff    <= next_v_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_free_ff   <= is_free_in;
      need_ff      <= need_in;
      addr_ff      <= addr_in;
      units_ff     <= units_in;
      ins_base_ff  <= ins_base_in;
      ins_len_ff   <= ins_len_in;
      rd_ff        <= rd_in;
      pidx_ff      <= pidx_in;
      best_idx_ff  <= best_idx_in;
      dir_up_ff    <= dir_up_in;
      best_ff      <= best_in;
      prev_ff      <= prev_in;
      next_ff      <= next_in;
      pos_ff       <= pos_in;
      res_st_ff    <= res_st_in;
      res_addr_ff  <= res_addr_in;
      res_grant_ff <= res_grant_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("segment count beyond table depth");

   a_rover_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> ({1'b0, rover_ff} < count_ff))
      else $error("rover outside the table");

   a_heap_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, heap_top_ff} <= HEAP_UNITS)
      else $error("heap top beyond heap size");

endmodule

// ===== hdl/best_fit_segment_allocator_core.sv =====
// top level of the best-fit segment allocator
// an allocate that fits searches the table and takes from the best segment, and an exact fit
// also shifts the table down; growing the heap adds an insert scan, possibly a shift, and a
// second search; a free does an insert scan and may shift the table up or down
// one request in flight, the next is taken in the cycle after the result is published
// reset is synchronous: config, count, rover and heap top reset, table contents are left as is
module best_fit_segment_allocator_core #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // request_bytes[23:0], block_address[44:24], block_units[65:45]
   input  logic [71:0] req_tdata,
   // command[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // payload_address[20:0], granted_units[41:21], status[43:42]
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bfsa_pkg::CSR_IW-1:0] csr_index,
   input  logic [bfsa_pkg::AW-1:0]     csr_data
);
   import bfsa_pkg::*;

   localparam int PW = 2 * AW + ST_W;

   cmd_type       cmd;
   stat_type      stat;
   logic [PW-1:0] rsp_payload;

   assign csr_ready = 1'b1;

   bfsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bfsa_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_command (req_tuser[0]),
      .req_bytes   (req_tdata[23:0]),
      .req_address (req_tdata[44:24]),
      .req_units   (req_tdata[65:45]),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_payload (rsp_payload)
   );

   assign rsp_tdata = {4'b0, rsp_payload};

endmodule

// ===== tb/best_fit_segment_allocator_core_checker.sv =====
// checker of the best-fit segment allocator: predicts every response and compares it
module best_fit_segment_allocator_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [bfsa_pkg::CSR_IW-1:0] csr_index,
   input  logic [bfsa_pkg::AW-1:0]     csr_data,
   output int          fail_count,
   output int          pending
);
   import bfsa_pkg::*;

   localparam int NSEG = 64;

   typedef struct packed {
      logic [ST_W-1:0] status;
      logic [AW-1:0]   units;
      logic [AW-1:0]   addr;
   } grant_type;

   logic [AW-1:0] limit_reg, grow_reg;
   logic [AW-1:0] seg_base [NSEG];
   logic [AW-1:0] seg_len  [NSEG];
   int unsigned   seg_cnt, rover;
   logic [AW:0]   top;
   grant_type     grant_q[$];

   assign pending = grant_q.size();

   function automatic logic [AW-1:0] clip_len(longint v);
      return (v > longint'(LEN_MAX)) ? LEN_MAX : v[AW-1:0];
   endfunction

   function automatic void drop_seg(int unsigned i);
      for (int unsigned j = i; j + 1 < seg_cnt; j++) begin
         seg_base[j] = seg_base[j+1];
         seg_len[j]  = seg_len[j+1];
      end
      seg_cnt--;
   endfunction

   function automatic logic [ST_W-1:0] merge_in(longint base, longint len);
      int unsigned pos;
      bit mn, mp;
      longint sum;
      pos = 0;
      while (pos < seg_cnt && longint'(seg_base[pos]) <= base) pos++;
      mn = pos < seg_cnt && base + len == longint'(seg_base[pos]);
      mp = pos > 0 && longint'(seg_base[pos-1]) + longint'(seg_len[pos-1]) == base;
      if (mp) begin
         sum = longint'(seg_len[pos-1]) + len;
         if (mn) begin
            sum += longint'(seg_len[pos]);
            drop_seg(pos);
         end
         seg_len[pos-1] = clip_len(sum);
         rover = pos - 1;
      end else if (mn) begin
         seg_base[pos] = base[AW-1:0];
         seg_len[pos]  = clip_len(longint'(seg_len[pos]) + len);
         rover = pos > 0 ? pos - 1 : seg_cnt - 1;
      end else begin
         if (seg_cnt >= NSEG) return ST_TABLE_FULL;
         for (int unsigned j = seg_cnt; j > pos; j--) begin
            seg_base[j] = seg_base[j-1];
            seg_len[j]  = seg_len[j-1];
         end
         seg_base[pos] = base[AW-1:0];
         seg_len[pos]  = len[AW-1:0];
         seg_cnt++;
         rover = pos > 0 ? pos - 1 : seg_cnt - 1;
      end
      return ST_OK;
   endfunction

   function automatic int find_fit(longint need);
      int best;
      int unsigned start, i;
      best = -1;
      if (seg_cnt == 0) return -1;
      start = rover < seg_cnt ? rover : seg_cnt - 1;
      for (int unsigned k = 1; k <= seg_cnt; k++) begin
         i = (start + k) % seg_cnt;
         if (longint'(seg_len[i]) >= need &&
             (best < 0 || seg_len[i] < seg_len[best])) begin
            best = i;
            if (longint'(seg_len[i]) == need) break;
         end
      end
      return best;
   endfunction

   function automatic grant_type serve(logic cmd, logic [BYTES_W-1:0] bytes,
                                       logic [AW-1:0] baddr, logic [AW-1:0] bunits);
      grant_type g;
      longint need, grow, lim;
      int idx;
      int unsigned ui;
      g = '0;
      if (cmd) begin
         if (baddr == 0) g.status = ST_NULL_FREE;
         else if (bunits != 0) g.status = merge_in(longint'(baddr) - 1, longint'(bunits));
         return g;
      end
      need = (longint'(bytes) + UNIT_BYTES - 1) / UNIT_BYTES + 1;
      idx = find_fit(need);
      if (idx < 0) begin
         lim  = longint'(limit_reg) < longint'(HEAP_UNITS) ? longint'(limit_reg)
                                                            : longint'(HEAP_UNITS);
         grow = need > longint'(grow_reg) ? need : longint'(grow_reg);
         if (longint'(top) + grow > lim || grow > longint'(LEN_MAX)) begin
            g.status = ST_NO_HEAP;
         end else if (merge_in(longint'(top), grow) != ST_OK) begin
            g.status = ST_TABLE_FULL;
         end else begin
            top = top + grow[AW:0];
            idx = find_fit(need);
         end
      end
      if (idx >= 0) begin
         ui = idx;
         if (longint'(seg_len[ui]) == need) begin
            g.addr = seg_base[ui] + 1'b1;
            drop_seg(ui);
            rover = ui > 0 ? ui - 1 : (seg_cnt > 0 ? seg_cnt - 1 : 0);
         end else begin
            seg_len[ui] = seg_len[ui] - need[AW-1:0];
            g.addr = seg_base[ui] + seg_len[ui] + 1'b1;
            rover = ui > 0 ? ui - 1 : seg_cnt - 1;
         end
         g.units = need[AW-1:0];
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         limit_reg <= HEAP_LIMIT_RST;
         grow_reg  <= GROW_RST;
         seg_cnt   = 0;
         rover     = 0;
         top       = 0;
         grant_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HEAP_LIMIT) limit_reg <= csr_data;
            else if (csr_index == CSR_GROW) grow_reg <= csr_data;
         end
         if (req_tvalid && req_tready)
            grant_q.push_back(serve(req_tuser[0], req_tdata[23:0], req_tdata[44:24],
                                    req_tdata[65:45]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[43:0];
            if (grant_q.size() == 0) begin
               $error("response transfer with no request pending: %h", rsp_tdata);
               errs++;
            end else begin
               want = grant_q.pop_front();
               if (got.addr !== want.addr) begin
                  $error("payload_address expected %0d actual %0d", want.addr, got.addr);
                  errs++;
               end
               if (got.units !== want.units) begin
                  $error("granted_units expected %0d actual %0d", want.units, got.units);
                  errs++;
               end
               if (got.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

// ===== tb/best_fit_segment_allocator_core_tb.sv =====
// testbench top of the best-fit segment allocator: stimulus and verdict
module best_fit_segment_allocator_core_tb;
   import bfsa_pkg::*;

   localparam longint LIMIT_CYCLES = 2000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [AW-1:0]     csr_data = '0;
   int          fail_count, pending;
   int          send_idle, recv_idle;
   longint      cycle_count = 0;
   logic [AW-1:0] live_addr[$];
   logic [AW-1:0] live_units[$];

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   best_fit_segment_allocator_core DUT (.*);

   best_fit_segment_allocator_core_checker CHK (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver stall pattern and a record of live blocks for legal frees
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
      if (rsp_tvalid && rsp_tready && rsp_tdata[43:42] == ST_OK && rsp_tdata[41:21] != 0) begin
         live_addr.push_back(rsp_tdata[20:0]);
         live_units.push_back(rsp_tdata[41:21]);
      end
   end

   // valid stays high after a transfer until the next idle cycle or drain
   task automatic send(input logic cmd, input logic [23:0] bytes,
                       input logic [AW-1:0] baddr, input logic [AW-1:0] bunits);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, bunits, baddr, bytes};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [AW-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic free_live();
      int k;
      k = $urandom_range(live_addr.size() - 1);
      send(1'b1, 24'($urandom), live_addr[k], live_units[k]);
      live_addr.delete(k);
      live_units.delete(k);
   endtask

   task automatic random_item();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         send(1'b0, ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(600)),
              '0, 21'($urandom));
      else if (r < 85 && live_addr.size() > 0)
         free_live();
      else if (r < 90)
         send(1'b1, 24'($urandom), '0, 21'($urandom));
      else if (r < 95)
         send(1'b1, 24'($urandom), 21'($urandom_range(1, 4000)), 21'($urandom_range(1, 40)));
      else
         send(1'b1, 24'($urandom), 21'($urandom), 21'($urandom));
   endtask

   initial begin
      send_idle = 0;
      recv_idle = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes of sizes, exact fits, null and zero frees, exhaustion
      send(1'b0, 24'd0, '0, '0);
      send(1'b0, 24'd16, '0, '0);
      send(1'b0, 24'd17, '0, '0);
      send(1'b0, 24'hFFFFFF, '0, '0);
      send(1'b0, 24'd16352, '0, '0);
      send(1'b1, 24'hFFFFFF, '0, 21'd5);
      send(1'b1, 24'd0, 21'd100, '0);
      send(1'b1, 24'd0, 21'h1FFFFF, 21'h1FFFFF);
      send(1'b1, 24'd0, 21'd1048576, 21'd1048576);
      drain();
      write_reg(CSR_HEAP_LIMIT, 21'd1);
      write_reg(CSR_GROW, 21'd1);
      send(1'b0, 24'd100, '0, '0);
      drain();
      write_reg(CSR_HEAP_LIMIT, 21'h1FFFFF);
      write_reg(CSR_GROW, 21'd1048576);
      send(1'b0, 24'd1, '0, '0);
      send(1'b0, 24'd1, '0, '0);
      drain();
      // fragment the table until full with tiny frees at spaced addresses
      write_reg(CSR_GROW, 21'd1);
      for (int i = 0; i < 70; i++) send(1'b1, '0, 21'(1200000 + 3*i), 21'd1);
      send(1'b0, 24'd2000, '0, '0);
      drain();

      // phase 1: sender idles 9 percent, receiver 77 percent
      send_idle = 9;
      recv_idle = 77;
      write_reg(CSR_HEAP_LIMIT, 21'd1048576);
      write_reg(CSR_GROW, 21'd1024);
      for (int i = 0; i < 205; i++) random_item();
      drain();
      // phase 2: the other way round, small heap and small growth
      send_idle = 77;
      recv_idle = 9;
      write_reg(CSR_HEAP_LIMIT, 21'd3000);
      write_reg(CSR_GROW, 21'd7);
      for (int i = 0; i < 205; i++) random_item();
      drain();
      // phase 3: no idling
      send_idle = 0;
      recv_idle = 0;
      write_reg(CSR_HEAP_LIMIT, 21'd1048575);
      write_reg(CSR_GROW, 21'd300);
      for (int i = 0; i < 205; i++) random_item();
      drain();

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
